[design/rleenc_pkg.sv]
// Shared constants and types of the run-length escape encoder.
`default_nettype none
package rleenc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEVEL_W = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd6;
    localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 4'd0;

    localparam logic [BYTE_W-1:0] RUN_MARK = 8'd255;
    localparam logic [BYTE_W-1:0] RUN_CAP  = 8'd255;
    localparam logic [BYTE_W-1:0] RUN_MIN  = 8'd4;
    localparam logic [BYTE_W-1:0] ESC_LEN  = 8'd1;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    // byte position inside a three-byte group
    localparam logic [1:0] POS_MARK = 2'd0;
    localparam logic [1:0] POS_LEN  = 2'd1;
    localparam logic [1:0] POS_VAL  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] length;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic a_valid;
        cmd_t a;
        logic b_valid;
        cmd_t b;
    } push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    typedef struct packed {
        logic              room;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic run_open;
    } front_stat_t;

endpackage
`default_nettype wire

[design/rleenc_if.sv]
// Handshake channels of the encoder: input bytes, encoded bytes, level writes.
`default_nettype none
interface rleenc_in_if;
    import rleenc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface rleenc_out_if;
    import rleenc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    modport source(output valid, output out_byte, output out_last, input ready);
    modport sink(input valid, input out_byte, input out_last, output ready);
endinterface

interface rleenc_cfg_if;
    import rleenc_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    modport source(output valid, output level, input ready);
    modport sink(input valid, input level, output ready);
endinterface
`default_nettype wire

[design/rleenc_front.sv]
// Front end: holds the current run and turns each input word into flush commands.
`default_nettype none
module rleenc_front (
    input  logic                     clk,
    input  logic                     rst_n,
    rleenc_in_if.sink                src,
    rleenc_cfg_if.sink               cfg,
    input  rleenc_pkg::q_stat_t      q_stat,
    output rleenc_pkg::push_t        push,
    output rleenc_pkg::front_stat_t  stat
);
    import rleenc_pkg::*;

    logic [LEVEL_W-1:0] level_reg;
    logic               run_open_reg, run_open_next;
    logic [BYTE_W-1:0]  run_value_reg, run_value_next;
    logic [BYTE_W-1:0]  run_length_reg, run_length_next;

    logic              accept;
    logic              same;
    logic              a_flush;
    logic              b_flush;
    logic [BYTE_W-1:0] new_len;

    assign src.ready = q_stat.room;
    assign cfg.ready = 1'b1;
    assign accept    = src.valid & q_stat.room;
    assign stat.run_open = run_open_reg;

    always_comb
    begin
        same = run_open_reg && (run_value_reg == src.data_byte);
        if (level_reg == LEVEL_OFF)
        begin
            a_flush = run_open_reg;
            new_len = ESC_LEN;
            b_flush = 1'b1;
        end
        else
        begin
            a_flush = run_open_reg && !same;
            new_len = same ? (run_length_reg + 8'd1) : 8'd1;
            b_flush = (new_len == RUN_CAP) || src.last_byte;
        end

        push.a_valid  = accept & a_flush;
        push.a.value  = run_value_reg;
        push.a.length = run_length_reg;
        push.a.last   = 1'b0;
        push.b_valid  = accept & b_flush;
        push.b.value  = src.data_byte;
        push.b.length = new_len;
        push.b.last   = src.last_byte;

        run_open_next   = run_open_reg;
        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;
        if (accept)
        begin
            run_value_next = src.data_byte;
            if (b_flush)
            begin
                run_open_next   = 1'b0;
                run_length_next = '0;
            end
            else
            begin
                run_open_next   = 1'b1;
                run_length_next = new_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= LEVEL_RESET;
            run_open_reg   <= 1'b0;
            run_value_reg  <= '0;
            run_length_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                level_reg <= cfg.level;
            end
            run_open_reg   <= run_open_next;
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule
`default_nettype wire

[design/rleenc_queue.sv]
// Command queue: up to two pushes and one pop per cycle.
`default_nettype none
module rleenc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rleenc_pkg::push_t    push,
    input  logic                 pop,
    output rleenc_pkg::head_t    head,
    output rleenc_pkg::q_stat_t  stat
);
    import rleenc_pkg::*;

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] b_ptr;
    logic [QCNT_W-1:0] n_push;

    assign b_ptr  = push.a_valid ? (wr_ptr_reg + 2'd1) : wr_ptr_reg;
    assign n_push = QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push[QPTR_W-1:0];
        rd_ptr_next = pop ? (rd_ptr_reg + 2'd1) : rd_ptr_reg;
        count_next  = count_reg + n_push - QCNT_W'(pop);
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];
    assign stat.room  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign stat.count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push.a_valid)
        begin
            q_reg[wr_ptr_reg] <= push.a;
        end
        if (push.b_valid)
        begin
            q_reg[b_ptr] <= push.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[design/rleenc_back.sv]
// Back end: expands each command into run tokens or literals, one byte a cycle while dst accepts.
`default_nettype none
module rleenc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rleenc_pkg::head_t  head,
    output logic               pop,
    rleenc_out_if.source       dst
);
    import rleenc_pkg::*;

    logic              cmd_valid_reg, cmd_valid_next;
    cmd_t              cmd_reg;
    logic [1:0]        pos_reg, pos_next;
    logic [1:0]        rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              step;
    logic              is_tok;
    logic              grp3;
    logic              grp_end;
    logic              cmd_end;
    logic [BYTE_W-1:0] cur_byte;

    assign dst.valid    = out_valid_reg;
    assign dst.out_byte = out_byte_reg;
    assign dst.out_last = out_last_reg;

    always_comb
    begin
        step    = cmd_valid_reg && (!out_valid_reg || dst.ready);
        is_tok  = cmd_reg.length >= RUN_MIN;
        grp3    = is_tok || (cmd_reg.value == RUN_MARK);
        case (pos_reg)
            POS_MARK: cur_byte = grp3 ? RUN_MARK : cmd_reg.value;
            POS_LEN:  cur_byte = is_tok ? cmd_reg.length : ESC_LEN;
            default:  cur_byte = cmd_reg.value;
        endcase
        grp_end = !grp3 || (pos_reg == POS_VAL);
        cmd_end = grp_end && (rem_reg == 2'd1);
        pop     = head.valid && (!cmd_valid_reg || (step && cmd_end));

        cmd_valid_next = cmd_valid_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        if (pop)
        begin
            cmd_valid_next = 1'b1;
            pos_next       = POS_MARK;
            rem_next       = (head.cmd.length >= RUN_MIN) ? 2'd1 : head.cmd.length[1:0];
        end
        else if (step && cmd_end)
        begin
            cmd_valid_next = 1'b0;
        end
        else if (step)
        begin
            if (grp_end)
            begin
                pos_next = POS_MARK;
                rem_next = rem_reg - 2'd1;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end

        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (dst.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head.cmd;
        end
        if (step)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cmd_reg.last && cmd_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            pos_reg       <= POS_MARK;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[design/rle_escape_byte_encoder.sv]
// Top level of the run-length encoder with escape byte.
//
//  channel  dir  payload                  moves
//  cfg      in   level[3:0]               one level write per word
//  src      in   data_byte[7:0],last_byte one message byte per word
//  dst      out  out_byte[7:0],out_last   one encoded byte per word
//
// src takes a word every cycle while the command queue has two free slots.
// dst gives one byte a cycle while commands wait and dst is ready; a run token or an escaped 255 is three bytes.
// A byte passes the queue, the back end's command register and its output register before it reaches dst.
// Reset: level 6, no run held, queue and output empty; no clearing pass.
// Stalls on dst back up into the 4-entry queue, then hold src.
`default_nettype none
module rle_escape_byte_encoder (
    input  logic          clk,
    input  logic          rst_n,
    rleenc_cfg_if.sink    cfg,
    rleenc_in_if.sink     src,
    rleenc_out_if.source  dst
);
    import rleenc_pkg::*;

    push_t       push;
    head_t       head;
    q_stat_t     q_stat;
    front_stat_t front_stat;
    logic        pop;

    rleenc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src),
        .cfg    (cfg),
        .q_stat (q_stat),
        .push   (push),
        .stat   (front_stat)
    );

    rleenc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (q_stat)
    );

    rleenc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .dst   (dst)
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty command queue");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("command queue overflow");

    a_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (src.valid && src.ready && src.last_byte) |=> !front_stat.run_open)
        else $error("run still held after last byte");

    a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (src.valid && src.ready && src.last_byte) |-> (push.b_valid && push.b.last))
        else $error("last byte produced no final command");

endmodule
`default_nettype wire
